// ===== src/scx_pkg.sv =====
`timescale 1ns / 1ps

package scx_pkg;

  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned CfgWW    = 12;
  localparam int unsigned CfgHW    = 16;
  localparam int unsigned PixW     = 8;
  localparam int unsigned PosW     = 27;
  localparam int unsigned DivCntW  = $clog2(PosW + 1);
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  localparam logic [CfgWW-1:0] WidthMin  = CfgWW'(3);
  localparam logic [CfgWW-1:0] WidthMax  = CfgWW'(MaxWidth);
  localparam logic [CfgHW-1:0] HeightMin = CfgHW'(3);
  localparam logic [CfgWW-1:0] WidthRst  = CfgWW'(640);
  localparam logic [CfgHW-1:0] HeightRst = CfgHW'(480);
  localparam logic [PosW-1:0]  TotalRst  = PosW'(640 * 480);

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } pos_state_e;

  typedef struct packed {
    logic [CfgWW-1:0] width;
    logic [CfgHW-1:0] height;
    logic [PosW-1:0]  total;
    logic             update;
  } scx_geom_t;

  typedef struct packed {
    logic            emit;
    logic            interior;
    logic            frame_end;
    logic [ColW-1:0] col;
    logic [PixW-1:0] value;
  } scx_item_t;

endpackage

// ===== src/scx_if.sv =====
`timescale 1ns / 1ps

interface scx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;
  logic       pad;

  modport source (output valid, output pixel_in, output pad, input ready);
  modport sink (input valid, input pixel_in, input pad, output ready);
endinterface

interface scx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

// ===== src/scx_ram.sv =====
`timescale 1ns / 1ps

module scx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/scx_cfg.sv =====
`timescale 1ns / 1ps

module scx_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [scx_pkg::AddrW-1:0] paddr,
  input  logic [scx_pkg::DataW-1:0] pwdata,
  output logic [scx_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output scx_pkg::scx_geom_t        geom_o
);

  import scx_pkg::*;

  logic [CfgWW-1:0]       width_q;
  logic [CfgHW-1:0]       height_q;
  logic [PosW-1:0]        total_q;
  logic [PosW-1:0]        total_d;
  logic [CfgWW-1:0]       w_eff;
  logic [CfgHW-1:0]       h_eff;
  logic [CfgWW+CfgHW-1:0] prod;
  logic                   wr;
  reg_idx_e               idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    priority if (width_q < WidthMin) begin
      w_eff = WidthMin;
    end else if (width_q > WidthMax) begin
      w_eff = WidthMax;
    end else begin
      w_eff = width_q;
    end
  end

  assign h_eff   = (height_q < HeightMin) ? HeightMin : height_q;
  assign prod    = {{CfgHW{1'b0}}, w_eff} * {{CfgWW{1'b0}}, h_eff};
  assign total_d = prod[PosW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      total_q  <= TotalRst;
    end else begin
      total_q <= total_d;
      if (wr) begin
        unique case (idx)
          REG_WIDTH:  width_q  <= pwdata[CfgWW-1:0];
          REG_HEIGHT: height_q <= pwdata[CfgHW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = {{(DataW-CfgWW){1'b0}}, width_q};
      REG_HEIGHT: prdata = {{(DataW-CfgHW){1'b0}}, height_q};
      default:    prdata = '0;
    endcase
  end

  assign geom_o.width  = w_eff;
  assign geom_o.height = h_eff;
  assign geom_o.total  = total_q;
  assign geom_o.update = wr;

endmodule

// ===== src/scx_pos.sv =====
`timescale 1ns / 1ps

module scx_pos (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scx_pkg::scx_geom_t geom_i,
  scx_in_if.sink             px_in_i,
  input  logic               take_i,
  output logic               fire_o,
  output scx_pkg::scx_item_t item_o
);

  import scx_pkg::*;

  pos_state_e        st_q, st_d;
  logic [ColW-1:0]   in_col_q, in_col_d;
  logic [CfgHW-1:0]  in_row_q, in_row_d;
  logic [PosW-1:0]   out_pos_q, out_pos_d;
  logic [ColW-1:0]   out_col_q, out_col_d;
  logic [CfgHW-1:0]  out_row_q, out_row_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [ColW-1:0]   rem_q, rem_d;
  logic [PosW-1:0]   quo_q, quo_d;

  logic              acc, tail, ignore, emit, col_wrap, fend, interior;
  logic [CfgWW-1:0]  in_col_nx, out_col_nx;
  logic [CfgHW:0]    out_row_nx;
  logic [PosW:0]     out_pos_nx;
  logic [CfgWW-1:0]  sh;
  logic              ge;
  logic [CfgWW-1:0]  sh_sub;
  logic [ColW-1:0]   step_rem;
  logic [PosW-1:0]   step_quo;
  logic [CfgHW-1:0]  step_row;

  assign px_in_i.ready = (st_q == ST_RUN) && take_i;
  assign acc    = px_in_i.valid && px_in_i.ready;
  assign tail   = in_row_q >= geom_i.height;
  assign ignore = px_in_i.pad && !tail;
  assign fire_o = acc && !ignore;

  assign emit = tail || (in_row_q >= CfgHW'(2)) ||
                ((in_row_q == CfgHW'(1)) && (in_col_q != '0));

  assign in_col_nx  = CfgWW'(in_col_q) + CfgWW'(1);
  assign col_wrap   = in_col_nx >= geom_i.width;
  assign out_pos_nx = {1'b0, out_pos_q} + (PosW+1)'(1);
  assign fend       = out_pos_nx >= {1'b0, geom_i.total};
  assign out_col_nx = CfgWW'(out_col_q) + CfgWW'(1);
  assign out_row_nx = {1'b0, out_row_q} + (CfgHW+1)'(1);
  assign interior   = (out_row_q != '0) && (out_row_nx < {1'b0, geom_i.height}) &&
                      (out_col_q != '0) && (out_col_nx < geom_i.width);

  assign item_o.emit      = emit;
  assign item_o.interior  = interior;
  assign item_o.frame_end = emit && fend;
  assign item_o.col       = in_col_q;
  assign item_o.value     = tail ? '0 : px_in_i.pixel_in;

  // restoring divide of the output position by the row width
  assign sh       = {rem_q, quo_q[PosW-1]};
  assign ge       = sh >= geom_i.width;
  assign sh_sub   = sh - geom_i.width;
  assign step_rem = ge ? sh_sub[ColW-1:0] : sh[ColW-1:0];
  assign step_quo = {quo_q[PosW-2:0], ge};
  assign step_row = (|step_quo[PosW-1:CfgHW]) ? '1 : step_quo[CfgHW-1:0];

  always_comb begin
    st_d      = st_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_pos_d = out_pos_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    unique case (st_q)
      ST_RUN: begin
        if (fire_o) begin
          if (col_wrap) begin
            in_col_d = '0;
            if (!tail) begin
              in_row_d = in_row_q + CfgHW'(1);
            end
          end else begin
            in_col_d = in_col_nx[ColW-1:0];
          end
          if (emit) begin
            if (fend) begin
              in_col_d  = '0;
              in_row_d  = '0;
              out_pos_d = '0;
              out_col_d = '0;
              out_row_d = '0;
            end else begin
              out_pos_d = out_pos_nx[PosW-1:0];
              if (out_col_nx >= geom_i.width) begin
                out_col_d = '0;
                if (out_row_q != '1) begin
                  out_row_d = out_row_nx[CfgHW-1:0];
                end
              end else begin
                out_col_d = out_col_nx[ColW-1:0];
              end
            end
          end
        end
      end
      ST_DIV: begin
        rem_d = step_rem;
        quo_d = step_quo;
        cnt_d = cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          out_col_d = step_rem;
          out_row_d = step_row;
          st_d      = ST_RUN;
        end
      end
      default: st_d = ST_RUN;
    endcase
    if (geom_i.update) begin
      st_d  = ST_DIV;
      cnt_d = DivCntW'(PosW);
      rem_d = '0;
      quo_d = out_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_RUN;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_pos_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      cnt_q     <= '0;
    end else begin
      st_q      <= st_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_pos_q <= out_pos_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN) |-> (CfgWW'(out_col_q) < geom_i.width))
    else $error("output column beyond row width");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_o && item_o.frame_end && !geom_i.update) |=>
      (out_pos_q == '0 && in_row_q == '0 && in_col_q == '0))
    else $error("counters not cleared after frame end");

endmodule

// ===== src/scx_stencil.sv =====
`timescale 1ns / 1ps

module scx_stencil (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  scx_pkg::scx_item_t item_i,
  output logic               take_o,
  scx_out_if.source          px_out_o
);

  import scx_pkg::*;

  logic            b_valid_q;
  scx_item_t       b_q;
  logic            b_fire, out_free;
  logic            byp, byp_q;
  logic [PixW-1:0] byp_a_q, byp_b_q;
  logic [PixW-1:0] ram_a, ram_b, a_eff, b_eff;
  logic [PixW-1:0] n_q, c_q, w_q, s_q;
  logic [10:0]     five_c;
  logic [9:0]      nsum;
  logic signed [11:0] diff;
  logic [PixW-1:0] clamped;
  logic            out_valid_q;
  logic [PixW-1:0] out_pix_q;
  logic            out_fe_q;

  assign out_free = !out_valid_q || px_out_o.ready;
  assign b_fire   = b_valid_q && (!b_q.emit || out_free);
  assign take_o   = !b_valid_q || b_fire;
  assign byp      = fire_i && b_fire && (item_i.col == b_q.col);

  scx_ram #(.Width(PixW), .Depth(MaxWidth)) u_line_two_above (
    .clk_i     (clk_i),
    .wr_en_i   (b_fire),
    .wr_addr_i (b_q.col),
    .wr_data_i (b_eff),
    .rd_en_i   (fire_i),
    .rd_addr_i (item_i.col),
    .rd_data_o (ram_a)
  );

  scx_ram #(.Width(PixW), .Depth(MaxWidth)) u_line_above (
    .clk_i     (clk_i),
    .wr_en_i   (b_fire),
    .wr_addr_i (b_q.col),
    .wr_data_i (b_q.value),
    .rd_en_i   (fire_i),
    .rd_addr_i (item_i.col),
    .rd_data_o (ram_b)
  );

  assign a_eff = byp_q ? byp_a_q : ram_a;
  assign b_eff = byp_q ? byp_b_q : ram_b;

  // 5*centre - north - south - west - east
  assign five_c = {1'b0, c_q, 2'b00} + {3'b000, c_q};
  assign nsum   = {2'b00, n_q} + {2'b00, s_q} + {2'b00, w_q} + {2'b00, b_eff};
  assign diff   = $signed({1'b0, five_c}) - $signed({2'b00, nsum});

  always_comb begin
    priority if (diff < 0) begin
      clamped = '0;
    end else if (diff > 12'sd255) begin
      clamped = '1;
    end else begin
      clamped = diff[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      c_q         <= '0;
      w_q         <= '0;
      s_q         <= '0;
    end else begin
      if (fire_i) begin
        b_valid_q <= 1'b1;
        byp_q     <= byp;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        n_q <= a_eff;
        w_q <= c_q;
        c_q <= b_eff;
        s_q <= b_q.value;
      end
      if (b_fire && b_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (px_out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      b_q     <= item_i;
      byp_a_q <= b_eff;
      byp_b_q <= b_q.value;
    end
    if (b_fire && b_q.emit) begin
      out_pix_q <= b_q.interior ? clamped : '0;
      out_fe_q  <= b_q.frame_end;
    end
  end

  assign px_out_o.valid     = out_valid_q;
  assign px_out_o.pixel_out = out_pix_q;
  assign px_out_o.frame_end = out_fe_q;

  a_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && b_q.emit && !b_q.interior) |=> (out_pix_q == '0))
    else $error("border word not zero");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_q.emit && out_valid_q && !px_out_o.ready) |-> !b_fire)
    else $error("stencil stage overwrote a waiting word");

endmodule

// ===== src/sharpen_3x3_cross_filter.sv =====
`timescale 1ns / 1ps

// 3x3 cross sharpening filter for an 8-bit grayscale raster stream. Each
// result is 5*centre minus the four direct neighbours, clamped to 0..255;
// border pixels give 0. One pixel word is taken per clock and a result word
// leaves per clock while the output is ready: the input register and the
// line-store read form one stage, and the stencil math feeds the output
// register, so a result is loaded into the output register when the item
// that completes it leaves the input stage. Results lag input by
// image_width+1 words; after the last pixel of a frame, send image_width+1
// pad words to flush it (frame_end marks the last result). Pads arriving
// mid-frame are dropped. Registers: image_width at 0x0, image_height at 0x4.
// Each register write restarts a bit-per-cycle division of the output
// position by the row width, and no pixel is taken while it runs; otherwise
// the rate is set by the two-port line stores, one read and one write per
// clock.

module sharpen_3x3_cross_filter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  scx_in_if.sink                    px_in_i,
  scx_out_if.source                 px_out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [scx_pkg::AddrW-1:0] paddr,
  input  logic [scx_pkg::DataW-1:0] pwdata,
  output logic [scx_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  import scx_pkg::*;

  scx_geom_t geom;
  scx_item_t item;
  logic      fire;
  logic      take;

  scx_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom_o  (geom)
  );

  scx_pos u_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .geom_i  (geom),
    .px_in_i (px_in_i),
    .take_i  (take),
    .fire_o  (fire),
    .item_o  (item)
  );

  scx_stencil u_stencil (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .take_o   (take),
    .px_out_o (px_out_o)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import scx_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int SettleCycles = 8;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            frame_end;
  } sharp_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  scx_in_if  pix_in ();
  scx_out_if pix_out ();

  sharpen_3x3_cross_filter dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .px_in_i  (pix_in),
    .px_out_o (pix_out),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // filter image held by the bench
  logic [CfgWW-1:0] cfg_w;
  logic [CfgHW-1:0] cfg_h;
  bit [7:0]         line_up [MaxWidth];
  bit [7:0]         line_up2 [MaxWidth];
  bit [7:0]         win [9];
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  int unsigned      opos;
  sharp_word_t      sharpened_q [$];

  int  errors;
  int  frames_done;
  int  results_seen;
  int  items_used;
  int  cfg_writes;
  int  quiet_cycles;
  int  pix_mode;
  int  pause_pct;
  bit  src_idle;
  bit  snk_idle;
  int  snk_hold;
  int  snk_gap;

  function automatic int unsigned eff_w();
    if (cfg_w < 3) return 3;
    if (cfg_w > MaxWidth) return MaxWidth;
    return cfg_w;
  endfunction

  function automatic int unsigned eff_h();
    return (cfg_h < 3) ? 3 : cfg_h;
  endfunction

  function automatic void sharpen_step(input logic [7:0] pix, input logic pad);
    int unsigned w, h, col, r, c;
    logic        tail, emit;
    logic [7:0]  v;
    int          acc;
    sharp_word_t res;
    w = eff_w();
    h = eff_h();
    tail = (row_cnt >= h);
    if (pad && !tail) return;
    items_used++;
    v = tail ? 8'd0 : pix;
    col = (col_cnt >= MaxWidth) ? 0 : col_cnt;
    win[0] = win[1]; win[1] = win[2]; win[2] = line_up2[col];
    win[3] = win[4]; win[4] = win[5]; win[5] = line_up[col];
    win[6] = win[7]; win[7] = win[8]; win[8] = v;
    line_up2[col] = line_up[col];
    line_up[col] = v;
    emit = tail || row_cnt >= 2 || (row_cnt == 1 && col_cnt >= 1);
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt < h) row_cnt++;
    end else begin
      col_cnt++;
    end
    if (!emit) return;
    r = opos / w;
    c = opos % w;
    res.pixel = 8'd0;
    if (r != 0 && r + 1 < h && c != 0 && c + 1 < w) begin
      acc = 5 * int'(win[4]) - int'(win[1]) - int'(win[7]) - int'(win[3]) - int'(win[5]);
      res.pixel = (acc < 0) ? 8'd0 : (acc > 255) ? 8'd255 : 8'(acc);
    end
    res.frame_end = (opos + 1 >= w * h);
    if (res.frame_end) begin
      row_cnt = 0;
      col_cnt = 0;
      opos = 0;
      frames_done++;
    end else begin
      opos++;
    end
    sharpened_q.push_back(res);
  endfunction

  function automatic logic [7:0] next_pixel();
    case (pix_mode)
      1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      2: return 8'($urandom_range(96, 160));
      default: return 8'($urandom);
    endcase
  endfunction

  // output side: per-word random stall, plus long hold-off on request
  always @(posedge clk_i) begin
    if (pix_out.valid === 1'b1 && pix_out.ready === 1'b1)
      snk_gap = snk_idle ? $urandom_range(0, 16) : 0;
    if (snk_hold > 0) begin
      snk_hold--;
      pix_out.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sharp_word_t want;
    if (rst_ni === 1'b1 && pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
      results_seen++;
      if (sharpened_q.size() == 0) begin
        $display("%0t: unexpected word, pixel_out %0d frame_end %0b", $time,
                 pix_out.pixel_out, pix_out.frame_end);
        errors++;
      end else begin
        want = sharpened_q.pop_front();
        if (pix_out.pixel_out !== want.pixel) begin
          $display("%0t: pixel_out expected %0d, got %0d", $time, want.pixel,
                   pix_out.pixel_out);
          errors++;
        end
        if (pix_out.frame_end !== want.frame_end) begin
          $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end,
                   pix_out.frame_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (pix_in.valid === 1'b1 && pix_in.ready === 1'b1) ||
        (pix_out.valid === 1'b1 && pix_out.ready === 1'b1) ||
        (psel === 1'b1 && penable === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no word accepted for %0d cycles", $time, quiet_cycles);
        $display("sharpen_3x3_cross_filter: mismatch");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [7:0] pix, input logic pad);
    int gap;
    gap = src_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.pixel_in <= pix;
    pix_in.pad <= pad;
    do @(posedge clk_i); while (pix_in.ready !== 1'b1);
    sharpen_step(pix, pad);
  endtask

  task automatic wait_idle();
    pix_in.valid <= 1'b0;
    while (sharpened_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_register(input reg_idx_e idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WIDTH) cfg_w = data[CfgWW-1:0];
    else cfg_h = data[CfgHW-1:0];
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // one frame until frame_end; optional height rewrite at the start of row cut_row
  task automatic run_frame(input int pad_pct, input int flush_pix_pct, input int cut_row,
                           input logic [15:0] cut_h);
    int start;
    bit cut_pending;
    start = frames_done;
    cut_pending = (cut_row > 0);
    while (frames_done == start) begin
      if (row_cnt < eff_h()) begin
        if (col_cnt == 0 && row_cnt > 0) begin
          if (cut_pending && row_cnt == cut_row) begin
            wait_idle();
            set_register(REG_HEIGHT, 32'(cut_h));
            cut_pending = 1'b0;
            continue;
          end else if ($urandom_range(0, 99) < pause_pct) begin
            wait_idle();
          end
        end
        if ($urandom_range(0, 99) < pad_pct) send_word(8'($urandom), 1'b1);
        else send_word(next_pixel(), 1'b0);
      end else begin
        send_word(8'($urandom), ($urandom_range(0, 99) < flush_pix_pct) ? 1'b0 : 1'b1);
      end
    end
  endtask

  task automatic test_border_and_clamp();
    logic [7:0] bright [9];
    logic [7:0] dark [9];
    bright = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    dark = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
    src_idle = 1'b1;
    snk_idle = 1'b1;
    set_register(REG_WIDTH, 32'd0);
    set_register(REG_HEIGHT, 32'd0);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_word(8'hFF, 1'b1);
      send_word(bright[i], 1'b0);
    end
    send_word(8'hA5, 1'b0);
    repeat (3) send_word(8'h5A, 1'b1);
    send_word(8'h00, 1'b1);
    wait_idle();
    set_register(REG_WIDTH, 32'd2);
    set_register(REG_HEIGHT, 32'd2);
    for (int i = 0; i < 9; i++) send_word(dark[i], 1'b0);
    repeat (4) send_word(8'h00, 1'b1);
  endtask

  task automatic test_midframe_height();
    wait_idle();
    pause_pct = 0;
    set_register(REG_WIDTH, 32'd6);
    set_register(REG_HEIGHT, 32'd8);
    run_frame(5, 20, 4, 16'd3);
    wait_idle();
    set_register(REG_HEIGHT, 32'd8);
    run_frame(5, 20, 5, 16'd3);
    wait_idle();
    run_frame(5, 20, 2, 16'd5);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    set_register(REG_WIDTH, 32'd20);
    set_register(REG_HEIGHT, 32'd8);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    pix_mode = 1;
    snk_hold = 400;
    run_frame(0, 0, 0, 16'd0);
    pix_mode = 0;
  endtask

  // oversized width clamps; part of the first row, then the row is narrowed
  task automatic test_widest_row();
    wait_idle();
    set_register(REG_WIDTH, 32'd4095);
    set_register(REG_HEIGHT, 32'd3);
    src_idle = 1'b1;
    snk_idle = 1'b1;
    pause_pct = 4;
    repeat (100) send_word(next_pixel(), 1'b0);
    wait_idle();
    set_register(REG_WIDTH, 32'd12);
    run_frame(2, 20, 0, 16'd0);
  endtask

  // full 16-bit height, cut short once the frame is well past the new size
  task automatic test_tallest_frame();
    wait_idle();
    set_register(REG_WIDTH, 32'd3);
    set_register(REG_HEIGHT, 32'd65535);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    pause_pct = 0;
    run_frame(0, 10, 40, 16'd0);
  endtask

  task automatic test_random_frames();
    int          start;
    int          sel;
    int unsigned w;
    int unsigned h;
    int          cut_row;
    logic [15:0] cut_h;
    start = items_used;
    pause_pct = 4;
    while (items_used - start < 1350) begin
      wait_idle();
      if ($urandom_range(0, 2) != 0) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) w = $urandom_range(0, 2);
        else if (sel == 1) w = $urandom_range(25, 160);
        else w = $urandom_range(3, 24);
        set_register(REG_WIDTH, ($urandom << CfgWW) | w);
      end
      if ($urandom_range(0, 2) != 0) begin
        h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
        if (eff_w() > 24 && h > 4) h = 4;
        set_register(REG_HEIGHT, ($urandom << CfgHW) | h);
      end
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      pix_mode = $urandom_range(0, 2);
      cut_row = 0;
      cut_h = '0;
      if ($urandom_range(0, 9) == 0) begin
        cut_row = $urandom_range(1, eff_h() - 1);
        cut_h = 16'($urandom_range(0, eff_h() + 4));
      end
      run_frame($urandom_range(0, 10), $urandom_range(0, 50), cut_row, cut_h);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pix_in.valid <= 1'b0;
    pix_in.pixel_in <= '0;
    pix_in.pad <= 1'b0;
    cfg_w = WidthRst;
    cfg_h = HeightRst;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_border_and_clamp();
    test_midframe_height();
    test_output_backpressure();
    test_widest_row();
    test_tallest_frame();
    test_random_frames();
    wait_idle();

    $display("%0d frames, %0d result words, %0d input words, %0d register writes",
             frames_done, results_seen, items_used, cfg_writes);
    $display("clamping, borders, pads, width and height clamps, mid-frame geometry changes");
    if (errors == 0) begin
      $display("sharpen_3x3_cross_filter: match");
    end else begin
      $display("sharpen_3x3_cross_filter: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/scx_pkg.sv
src/scx_if.sv
src/scx_ram.sv
src/scx_cfg.sv
src/scx_pos.sv
src/scx_stencil.sv
src/sharpen_3x3_cross_filter.sv
bench/tb.sv
